// ----- src/eil_pkg.sv -----
// shared types, constants and helpers of the image extremum locator
package eil_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int SAMPLE_BITS = 32;

  localparam int CNT_W  = 12;  // column and row counters
  localparam int SIZE_W = 13;  // image width and height
  localparam int RAD_W  = 12;  // window radius
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int DSQ_W  = 2 * CNT_W + 1;
  localparam int DIF_W  = CNT_W + 2;
  localparam int IDX_W  = 24;  // linear pixel index
  localparam int POS_W  = IDX_W + 1;
  localparam int CFG_W  = 13;
  localparam int CIX_W  = 3;

  localparam logic [CIX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CIX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CIX_W-1:0] REG_WINDOW_RADIUS = 3'd2;
  localparam logic [CIX_W-1:0] REG_FIND_LOWEST   = 3'd3;
  localparam logic [CIX_W-1:0] REG_WINDOW_ENABLE = 3'd4;

  localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(64);
  localparam logic [RAD_W-1:0]  RST_RADIUS = RAD_W'(8);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [POS_W-1:0]       POS_NONE   = {POS_W{1'b1}};

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RSQ_W-1:0]  radius_sq;
    logic              find_lowest;
    logic              window_enable;
  } cfg_t;

  // pixel as taken from the input channel
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CNT_W-1:0]       col;
    logic [CNT_W-1:0]       row;
    logic                   first;
    logic                   last;
  } pix_t;

  // pixel with its distance and index worked out
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [DSQ_W-1:0]       dist_sq;
    logic [IDX_W-1:0]       index;
    logic                   first;
    logic                   last;
  } geo_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- src/image_extremum_locator.sv -----
// top level of the image extremum locator
//
// Pixels of one or more images enter on the in_ channel in raster order, one
// request per pixel. For each image the block finds the largest sample (or the
// smallest when find_lowest is set) and its linear index row*width+column, the
// first one winning on ties. With window_enable set, only pixels inside the
// circle of window_radius around (width/2, height/2) count, and the position
// is -1 when none of them beats the start value.
// One result request leaves on the out_ channel for the last pixel of each image.
// An image's last pixel passes the input register, the distance and index
// multipliers and the best compare before out_valid rises. Throughput: one pixel
// per cycle while in_ready is high, set by this three-register pipeline.
// The cfg_ port writes one register per cycle with cfg_wr_en; write it only while
// no pixel is in flight. Registers take effect on the next pixel.
// A synchronous reset clears the counters and the pipeline and loads the register
// defaults (64 x 64, radius 8, maximum search, full image).
// While a result waits on out_ready the block keeps taking pixels; it stalls
// in_ready only when the next finished image reaches the result register.
module image_extremum_locator import eil_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_extreme_value,
  output logic signed [POS_W-1:0]       out_extreme_position,
  input  logic                          cfg_wr_en,
  input  logic [CIX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata
);

  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic [RSQ_W-1:0]  radius_sq_r, radius_sq_nxt;
  logic              lowest_r, lowest_nxt;
  logic              win_en_r, win_en_nxt;
  logic [RAD_W-1:0]  wr_radius;
  cfg_t              cfg;
  logic              en;
  logic              a_valid, b_valid;
  pix_t              a_pix;
  geo_t              b_geo;

  assign wr_radius = cfg_wdata[RAD_W-1:0];

  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    radius_sq_nxt = radius_sq_r;
    lowest_nxt    = lowest_r;
    win_en_nxt    = win_en_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   width_nxt     = cfg_wdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:  height_nxt    = cfg_wdata[SIZE_W-1:0];
        REG_WINDOW_RADIUS: radius_sq_nxt = wr_radius * wr_radius;
        REG_FIND_LOWEST:   lowest_nxt    = cfg_wdata[0];
        REG_WINDOW_ENABLE: win_en_nxt    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= RST_WIDTH;
      height_r    <= RST_HEIGHT;
      radius_sq_r <= RSQ_W'(RST_RADIUS * RST_RADIUS);
      lowest_r    <= 1'b0;
      win_en_r    <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      radius_sq_r <= radius_sq_nxt;
      lowest_r    <= lowest_nxt;
      win_en_r    <= win_en_nxt;
    end
  end

  assign cfg.width         = clamp_size(width_r, SIZE_W'(MAX_WIDTH));
  assign cfg.height        = clamp_size(height_r, SIZE_W'(MAX_HEIGHT));
  assign cfg.radius_sq     = radius_sq_r;
  assign cfg.find_lowest   = lowest_r;
  assign cfg.window_enable = win_en_r;

  assign in_ready = en;

  eil_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .en        (en),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .a_valid   (a_valid),
    .a_pix     (a_pix)
  );

  eil_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .en      (en),
    .a_valid (a_valid),
    .a_pix   (a_pix),
    .b_valid (b_valid),
    .b_geo   (b_geo)
  );

  eil_track u_track (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .b_valid              (b_valid),
    .b_geo                (b_geo),
    .en                   (en),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_extreme_value    (out_extreme_value),
    .out_extreme_position (out_extreme_position)
  );

endmodule

// ----- src/eil_scan.sv -----
// input register and raster position counters
module eil_scan import eil_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   a_valid,
  output pix_t                   a_pix
);

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             a_valid_r, a_valid_nxt;
  pix_t             a_pix_r, a_pix_nxt;
  logic             last_col, last_row;
  logic             accept;

  assign accept   = en && in_valid;
  // a width shrunk mid-image ends the row at once
  assign last_col = ({1'b0, col_r} + SIZE_W'(1)) >= cfg.width;
  assign last_row = ({1'b0, row_r} + SIZE_W'(1)) >= cfg.height;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    a_valid_nxt = a_valid_r;
    a_pix_nxt   = a_pix_r;
    if (en) begin
      a_valid_nxt = in_valid;
    end
    if (accept) begin
      a_pix_nxt.sample = in_sample;
      a_pix_nxt.col    = col_r;
      a_pix_nxt.row    = row_r;
      a_pix_nxt.first  = (col_r == '0) && (row_r == '0);
      a_pix_nxt.last   = last_col && last_row;
      if (!last_col) begin
        col_nxt = col_r + CNT_W'(1);
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      a_valid_r <= a_valid_nxt;
    end
    a_pix_r <= a_pix_nxt;
  end

  assign a_valid = a_valid_r;
  assign a_pix   = a_pix_r;

endmodule

// ----- src/eil_geom.sv -----
// squared distance from the center and linear index of each pixel
module eil_geom import eil_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic en,
  input  logic a_valid,
  input  pix_t a_pix,
  output logic b_valid,
  output geo_t b_geo
);

  logic signed [DIF_W-1:0]   dx, dy;
  logic signed [2*DIF_W-1:0] dx_sq, dy_sq;
  logic [POS_W-1:0]          row_base;
  logic                      b_valid_r, b_valid_nxt;
  geo_t                      b_geo_r, b_geo_nxt;

  assign dx    = $signed({2'b00, a_pix.col}) - $signed({2'b00, cfg.width[SIZE_W-1:1]});
  assign dy    = $signed({2'b00, a_pix.row}) - $signed({2'b00, cfg.height[SIZE_W-1:1]});
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign row_base = {{(POS_W-CNT_W){1'b0}}, a_pix.row} * {{(POS_W-SIZE_W){1'b0}}, cfg.width};

  always_comb begin
    b_valid_nxt = b_valid_r;
    b_geo_nxt   = b_geo_r;
    if (en) begin
      b_valid_nxt       = a_valid;
      b_geo_nxt.sample  = a_pix.sample;
      // both offsets stay below 4096 in magnitude
      b_geo_nxt.dist_sq = {1'b0, dx_sq[DSQ_W-2:0]} + {1'b0, dy_sq[DSQ_W-2:0]};
      b_geo_nxt.index   = row_base[IDX_W-1:0] + {{(IDX_W-CNT_W){1'b0}}, a_pix.col};
      b_geo_nxt.first   = a_pix.first;
      b_geo_nxt.last    = a_pix.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
    b_geo_r <= b_geo_nxt;
  end

  assign b_valid = b_valid_r;
  assign b_geo   = b_geo_r;

endmodule

// ----- src/eil_track.sv -----
// running best compare and result register
module eil_track import eil_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          b_valid,
  input  geo_t                          b_geo,
  output logic                          en,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_extreme_value,
  output logic signed [POS_W-1:0]       out_extreme_position
);

  logic signed [SAMPLE_BITS-1:0] best_r, best_nxt;
  logic signed [POS_W-1:0]       idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_value_r, out_value_nxt;
  logic signed [POS_W-1:0]       out_pos_r, out_pos_nxt;
  logic signed [SAMPLE_BITS-1:0] start, cur_best, new_best, smp;
  logic signed [POS_W-1:0]       cur_idx, new_idx;
  logic                          part, better, take, fire;

  // only a finished image can be held up by a full result register
  assign en    = !(b_valid && b_geo.last && out_valid_r && !out_ready);
  assign fire  = en && b_valid;

  assign smp      = $signed(b_geo.sample);
  assign start    = cfg.find_lowest ? SAMPLE_MAX : SAMPLE_MIN;
  assign cur_best = b_geo.first ? start : best_r;
  assign cur_idx  = b_geo.first ? POS_NONE : idx_r;
  assign part     = !cfg.window_enable || (b_geo.dist_sq <= {1'b0, cfg.radius_sq});
  assign better   = cfg.find_lowest ? (smp < cur_best) : (smp > cur_best);
  assign take     = part && ((!cfg.window_enable && b_geo.first) || better);
  assign new_best = take ? smp : cur_best;
  assign new_idx  = take ? $signed({1'b0, b_geo.index}) : cur_idx;

  always_comb begin
    best_nxt      = best_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      if (b_geo.last) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = new_best;
        out_pos_nxt   = new_idx;
        best_nxt      = start;
        idx_nxt       = POS_NONE;
      end else begin
        best_nxt = new_best;
        idx_nxt  = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= SAMPLE_MIN;
      idx_r       <= POS_NONE;
      out_valid_r <= 1'b0;
    end else begin
      best_r      <= best_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_extreme_value    = out_value_r;
  assign out_extreme_position = out_pos_r;

endmodule

// ----- src/eil_checker.sv -----
// port-level checks of the image extremum locator and their bind
module eil_checker import eil_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_extreme_value,
  input logic signed [POS_W-1:0]       out_extreme_position
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_extreme_value)
                                && $stable(out_extreme_position))
    else $error("stalled result changed");

  // a negative position can only be the no-pixel marker
  a_pos_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_extreme_position[POS_W-1] |-> &out_extreme_position)
    else $error("negative position other than -1");

  // input backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind image_extremum_locator eil_checker u_eil_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_extreme_value    (out_extreme_value),
  .out_extreme_position (out_extreme_position)
);

// ----- tb/sv/tb.sv -----
// testbench of the image extremum locator: streamed pixels checked against a running predictor
module tb;
  import eil_pkg::*;

  localparam int RANDOM_PIXELS = 1350;
  localparam int STRESS_IMAGES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic signed [POS_W-1:0]       position;
  } extremum_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_extreme_value;
  logic signed [POS_W-1:0]       out_extreme_position;
  logic                          cfg_wr_en = 1'b0;
  logic [CIX_W-1:0]              cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]              cfg_wdata = '0;

  // register copies seen by the predictor
  logic [SIZE_W-1:0] reg_width  = RST_WIDTH;
  logic [SIZE_W-1:0] reg_height = RST_HEIGHT;
  logic [RAD_W-1:0]  reg_radius = RST_RADIUS;
  logic              reg_lowest = 1'b0;
  logic              reg_window = 1'b0;

  // predictor state
  int                            col_pos = 0;
  int                            row_pos = 0;
  logic signed [SAMPLE_BITS-1:0] run_best = SAMPLE_MIN;
  logic signed [POS_W-1:0]       run_index = POS_NONE;

  logic signed [SAMPLE_BITS-1:0] pending_pixels[$];
  extremum_t                     expected_extrema[$];
  extremum_t                     oldest_extremum;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   pixels_taken = 0;
  int   results_seen = 0;
  int   settings_count = 0;
  int   fail_count = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  logic hold_request = 1'b0;
  logic hold_started = 1'b0;

  image_extremum_locator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_extreme_value    (out_extreme_value),
    .out_extreme_position (out_extreme_position),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int effective_size(input logic [SIZE_W-1:0] v, input int hi);
    int res;
    if (v == '0) begin
      res = 1;
    end else if (int'(v) > hi) begin
      res = hi;
    end else begin
      res = int'(v);
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] start_value();
    return reg_lowest ? SAMPLE_MAX : SAMPLE_MIN;
  endfunction

  // follows one accepted pixel and queues the image result at its last pixel
  task automatic locate_extremum(input logic signed [SAMPLE_BITS-1:0] s);
    int   w;
    int   h;
    int   dx;
    int   dy;
    int   r;
    logic first_px;
    logic part;
    logic take;
    w = effective_size(reg_width, MAX_WIDTH);
    h = effective_size(reg_height, MAX_HEIGHT);
    first_px = (col_pos == 0 && row_pos == 0);
    if (first_px) begin
      run_best  = start_value();
      run_index = POS_NONE;
    end
    dx = col_pos - w / 2;
    dy = row_pos - h / 2;
    r  = int'(reg_radius);
    part = !reg_window || (dx * dx + dy * dy <= r * r);
    if (!part) begin
      take = 1'b0;
    end else if (!reg_window && first_px) begin
      take = 1'b1;
    end else if (reg_lowest) begin
      take = s < run_best;
    end else begin
      take = s > run_best;
    end
    if (take) begin
      run_best  = s;
      run_index = POS_W'(row_pos * w + col_pos);
    end
    // counters past a shrunk size end the row or the image at once
    if (col_pos + 1 < w) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (row_pos + 1 < h) begin
        row_pos++;
      end else begin
        row_pos = 0;
        expected_extrema.push_back(extremum_t'{value: run_best, position: run_index});
        run_best  = start_value();
        run_index = POS_NONE;
      end
    end
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0: s = SAMPLE_MIN;
      1: s = SAMPLE_MAX;
      2, 3: s = SAMPLE_BITS'($signed($urandom_range(0, 6)) - 3);  // near zero, many ties
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        locate_extremum(in_sample);
        pixels_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker of result requests
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (expected_extrema.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("unexpected result: value %0d position %0d",
                     out_extreme_value, out_extreme_position);
          end
        end else begin
          oldest_extremum = expected_extrema.pop_front();
          results_seen++;
          if (out_extreme_value !== oldest_extremum.value ||
              out_extreme_position !== oldest_extremum.position) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("result %0d: value exp %0d got %0d, position exp %0d got %0d",
                       results_seen, oldest_extremum.value, out_extreme_value,
                       oldest_extremum.position, out_extreme_position);
            end
          end
        end
      end
    end
  end

  // long receiver stall, requested once by the stimulus
  always @(posedge clk) begin
    if (hold_request && !hold_started) begin
      hold_left    <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    case (idx)
      REG_IMAGE_WIDTH:   reg_width  = SIZE_W'(val);
      REG_IMAGE_HEIGHT:  reg_height = SIZE_W'(val);
      REG_WINDOW_RADIUS: reg_radius = RAD_W'(val);
      REG_FIND_LOWEST:   reg_lowest = val[0];
      REG_WINDOW_ENABLE: reg_window = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_setup(input int unsigned w, input int unsigned h, input int unsigned r,
                            input int unsigned lowest, input int unsigned window);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_RADIUS, r);
    write_reg(REG_FIND_LOWEST, lowest);
    write_reg(REG_WINDOW_ENABLE, window);
    settings_count++;
  endtask

  // wait until every pixel is taken and every result is back, then let the pipe drain
  task automatic settle();
    while (pending_pixels.size() != 0 || in_valid || expected_extrema.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int w_pick;
    int h_pick;
    int r_pick;
    int w_eff;
    int h_eff;
    int n;
    int random_count;
    random_count  = 0;
    send_idle_pct = 6;
    recv_idle_pct = 67;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // full maximum search, tie keeps the first maximum
    load_setup(3, 2, 1, 0, 0);
    pending_pixels.push_back(SAMPLE_MIN);
    pending_pixels.push_back(SAMPLE_MAX);
    pending_pixels.push_back(0);
    pending_pixels.push_back(SAMPLE_MAX);
    pending_pixels.push_back(-1);
    pending_pixels.push_back(1);
    settle();

    // zero width acts as one, first pixel always taken in full mode
    load_setup(0, 2, 1, 1, 0);
    pending_pixels.push_back(SAMPLE_MAX);
    pending_pixels.push_back(SAMPLE_MAX);
    settle();

    // radius zero: only the center counts, first image has nothing above the start value
    load_setup(3, 1, 0, 0, 1);
    pending_pixels.push_back(SAMPLE_MAX);
    pending_pixels.push_back(SAMPLE_MIN);
    pending_pixels.push_back(SAMPLE_MAX);
    pending_pixels.push_back(SAMPLE_MIN);
    pending_pixels.push_back(7);
    pending_pixels.push_back(SAMPLE_MAX);
    settle();

    // windowed minimum search
    load_setup(5, 1, 1, 1, 1);
    pending_pixels.push_back(SAMPLE_MIN);
    pending_pixels.push_back(32'sh5555_5555);
    pending_pixels.push_back(32'shAAAA_AAAA);
    pending_pixels.push_back(32'shAAAA_AAAA);
    pending_pixels.push_back(SAMPLE_MIN);
    settle();

    // sizes shrunk below the counters in the middle of an image
    load_setup(4, 4, 2, 0, 0);
    repeat (5) pending_pixels.push_back(random_sample());
    settle();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 2);
    pending_pixels.push_back(random_sample());
    settle();

    // oversized width and largest radius, then shrunk mid-image
    load_setup(8191, 4096, 4095, 0, 1);
    repeat (40) pending_pixels.push_back(random_sample());
    settle();
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 3);
    repeat (5) pending_pixels.push_back(random_sample());
    settle();

    // oversized height, then zero height ends the image
    load_setup(1, 8191, 3, 1, 0);
    repeat (10) pending_pixels.push_back(random_sample());
    settle();
    write_reg(REG_IMAGE_HEIGHT, 0);
    pending_pixels.push_back(random_sample());
    settle();

    // many tiny images while the receiver stalls, so the block backs up
    load_setup(3, 2, 1, 0, 0);
    hold_request <= 1'b1;
    repeat (STRESS_IMAGES * 6) pending_pixels.push_back(random_sample());
    random_count += STRESS_IMAGES * 6;
    settle();

    while (random_count < RANDOM_PIXELS) begin
      if (random_count < RANDOM_PIXELS / 3) begin
        send_idle_pct = 6;
        recv_idle_pct = 67;
      end else if (random_count < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      w_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      h_pick = (w_pick > 8) ? $urandom_range(1, 2) : $urandom_range(0, 8);
      r_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 5);
      load_setup(w_pick, h_pick, r_pick, $urandom_range(0, 1), $urandom_range(0, 1));
      w_eff = effective_size(SIZE_W'(w_pick), MAX_WIDTH);
      h_eff = effective_size(SIZE_W'(h_pick), MAX_HEIGHT);
      n = w_eff * h_eff * $urandom_range(1, 4);
      // sometimes stop inside an image so the next setting lands mid-image
      if ($urandom_range(0, 7) == 0 && w_eff * h_eff > 1) begin
        n += $urandom_range(1, w_eff * h_eff - 1);
      end
      if (n > RANDOM_PIXELS - random_count) begin
        n = RANDOM_PIXELS - random_count;
      end
      repeat (n) pending_pixels.push_back(random_sample());
      random_count += n;
      settle();
    end

    $display("checked %0d image results from %0d pixels over %0d register settings",
             results_seen, pixels_taken, settings_count);
    $display("both search modes, full and windowed, clamped sizes and a long output stall");
    if (fail_count == 0 && expected_extrema.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
